FILE: rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the baro compensation core
// Register indexes, fixed-point widths and pipeline depth.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMP_CAL = 2'd0,
    CFG_PRESS_A  = 2'd1,
    CFG_PRESS_B  = 2'd2,
    CFG_PRESS_C  = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  // Pipeline depth, input register to output register
  localparam int unsigned NumStages = 13;

  // Fixed-point widths (signed two's complement)
  localparam int unsigned TlW = 60;   // t_lin * 2^48
  localparam int unsigned B3W = 34;   // p8*2^22 + u*p4
  localparam int unsigned B2W = 34;   // p7*2^24 + u*p3
  localparam int unsigned XW  = 95;   // T*B3 + B2*2^53
  localparam int unsigned B1W = 63;   // p6*2^42 + u*(p2-2^14)*2^19 + u^2*p10
  localparam int unsigned YW  = 156;  // T*X + B1*2^85
  localparam int unsigned B0W = 89;   // p5*2^68 + u*(p1-2^14)*2^45 + u^2*p9*2^17 + u^3*p11
  localparam int unsigned SW  = 217;  // pressure * 2^181

  localparam int unsigned B2Sh = 53;
  localparam int unsigned B1Sh = 85;
  localparam int unsigned B0Sh = 116;

endpackage

FILE: rtl/core/bpc_mul_add.sv
// ----------------------------------------------------------------------------
// bpc_mul_add: pipelined wide signed multiply-add
// y = a * b + c * 2^CSH, split into 33x33 partial products, three stages.
// ----------------------------------------------------------------------------
module bpc_mul_add #(
  parameter int unsigned AW  = 60,
  parameter int unsigned BW  = 34,
  parameter int unsigned CW  = 34,
  parameter int unsigned CSH = 53,
  parameter int unsigned YW  = 95
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  input  logic signed [CW-1:0] c_i,
  output logic signed [YW-1:0] y_o
);

  localparam int unsigned NA = (AW + 31) / 32;
  localparam int unsigned NB = (BW + 31) / 32;

  logic signed [NA*32-1:0] a_ext;
  logic signed [NB*32-1:0] b_ext;
  logic signed [65:0]      pp_d [NA][NB];
  logic signed [65:0]      pp_q [NA][NB];
  logic signed [CW-1:0]    c1_q, c2_q;
  logic signed [YW-1:0]    row_d [NA];
  logic signed [YW-1:0]    row_q [NA];
  logic signed [YW-1:0]    y_d, y_q;

  assign a_ext = (NA*32)'(a_i);
  assign b_ext = (NB*32)'(b_i);

  // Partial products: top limbs signed, lower limbs unsigned
  always_comb begin
    logic signed [32:0] al, bl;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        al = (i == NA - 1) ? {a_ext[32*i+31], a_ext[32*i +: 32]}
                           : {1'b0, a_ext[32*i +: 32]};
        bl = (j == NB - 1) ? {b_ext[32*j+31], b_ext[32*j +: 32]}
                           : {1'b0, b_ext[32*j +: 32]};
        pp_d[i][j] = 66'(al) * 66'(bl);
      end
    end
  end

  // Sum each row of partial products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (YW'(pp_q[i][j]) <<< (32*j));
      end
    end
  end

  // Combine rows and add the shifted offset term
  always_comb begin
    y_d = YW'(c2_q) <<< CSH;
    for (int i = 0; i < NA; i++) begin
      y_d = y_d + (row_q[i] <<< (32*i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp_q <= pp_d;
      c1_q <= c_i;
    end
    if (en_i[1]) begin
      row_q <= row_d;
      c2_q  <= c1_q;
    end
    if (en_i[2]) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

FILE: rtl/core/baro_pressure_temp_compensation_core.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_core: barometric compensation pipeline
// Turns raw 24-bit pressure/temperature samples into compensated values.
// ----------------------------------------------------------------------------
// Usage:
//   Load the four calibration words over the cfg channel (index 0..3) while
//   no transaction is in flight; cfg_ready_o is always high.
//   Present a raw pressure/temperature pair on the input channel; each
//   accepted transaction yields exactly one result transaction carrying
//   temperature (1/256 degC), pressure (1/64 Pa) and a saturation flag.
//   Throughput is one transaction per cycle as long as the receiver keeps
//   out_ready_i high. The depth comes from the temperature
//   stages (3) followed by three Horner steps, each a 3-stage wide
//   multiply-add built from 33x33 partial products, and a final round stage.
//   Every stage carries its own valid bit. A stage advances when it is empty
//   or the stage after it advances, so bubbles collapse while the receiver
//   stalls and new transactions are still accepted until the pipe is full.
//   Reset clears all valid bits and all calibration words to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bpc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [bpc_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [23:0]                        raw_pressure_i,
  input  logic [23:0]                        raw_temperature_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [15:0]                 temperature_out_o,
  output logic [23:0]                        pressure_out_o,
  output logic                               clipped_o
);

  localparam int unsigned NST = bpc_pkg::NumStages;

  // --------------------------------------------------------------------------
  // Calibration registers
  // --------------------------------------------------------------------------
  logic [39:0] temp_cal_q;
  logic [47:0] press_a_q, press_b_q;
  logic [31:0] press_c_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      press_a_q  <= '0;
      press_b_q  <= '0;
      press_c_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (bpc_pkg::cfg_idx_e'(cfg_index_i))
        bpc_pkg::CFG_TEMP_CAL: temp_cal_q <= cfg_data_i[39:0];
        bpc_pkg::CFG_PRESS_A:  press_a_q  <= cfg_data_i;
        bpc_pkg::CFG_PRESS_B:  press_b_q  <= cfg_data_i;
        bpc_pkg::CFG_PRESS_C:  press_c_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Unpack calibration fields
  logic [15:0]        t1, t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;

  assign t1  = temp_cal_q[15:0];
  assign t2  = temp_cal_q[31:16];
  assign t3  = temp_cal_q[39:32];
  assign p1  = press_a_q[15:0];
  assign p2  = press_a_q[31:16];
  assign p3  = press_a_q[39:32];
  assign p4  = press_a_q[47:40];
  assign p5  = press_b_q[15:0];
  assign p6  = press_b_q[31:16];
  assign p7  = press_b_q[39:32];
  assign p8  = press_b_q[47:40];
  assign p9  = press_c_q[15:0];
  assign p10 = press_c_q[23:16];
  assign p11 = press_c_q[31:24];

  // --------------------------------------------------------------------------
  // Stage control: per-stage valid bits, advance on empty or downstream move
  // --------------------------------------------------------------------------
  logic [NST:1] v_q;
  logic [NST:1] en;

  always_comb begin
    en[NST] = !v_q[NST] || out_ready_i;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: temperature offset, u squared and products of u with calibration words
  // --------------------------------------------------------------------------
  logic signed [24:0] d_d, d_q;
  logic signed [16:0] p1m, p2m;
  logic [23:0]        u_q;
  logic signed [41:0] up1_d, up2_d, up1_q, up2_q, up1_2_q, up2_2_q;
  logic signed [32:0] up3_d, up4_d, up3_q, up4_q;
  logic [47:0]        uu_d, uu_q;

  assign p1m   = 17'(p1) - 17'sd16384;
  assign p2m   = 17'(p2) - 17'sd16384;
  assign d_d   = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, t1, 8'h00});
  assign up1_d = 42'($signed({1'b0, raw_pressure_i})) * 42'(p1m);
  assign up2_d = 42'($signed({1'b0, raw_pressure_i})) * 42'(p2m);
  assign up3_d = 33'($signed({1'b0, raw_pressure_i})) * 33'(p3);
  assign up4_d = 33'($signed({1'b0, raw_pressure_i})) * 33'(p4);
  assign uu_d  = 48'(raw_pressure_i) * 48'(raw_pressure_i);

  // --------------------------------------------------------------------------
  // Stage 2: d*t2, d*d, inner Horner coefficients, powers of u
  // --------------------------------------------------------------------------
  logic signed [41:0]         dt2_d, dt2_q;
  logic signed [49:0]         dd_d, dd_q;
  logic signed [bpc_pkg::B3W-1:0] b3_d, b3_q, b3_3_q;
  logic signed [bpc_pkg::B2W-1:0] b2_d, b2_q, b2_3_q;
  logic signed [56:0]         u2p10_d, u2p10_q;
  logic signed [64:0]         u2p9_d, u2p9_q;
  logic [71:0]                u3_d, u3_q;

  assign dt2_d   = 42'(d_q) * 42'($signed({1'b0, t2}));
  assign dd_d    = 50'(d_q) * 50'(d_q);
  assign b3_d    = (bpc_pkg::B3W'(p8) <<< 22) + bpc_pkg::B3W'(up4_q);
  assign b2_d    = (bpc_pkg::B2W'(p7) <<< 24) + bpc_pkg::B2W'(up3_q);
  assign u2p10_d = 57'($signed({1'b0, uu_q})) * 57'(p10);
  assign u2p9_d  = 65'($signed({1'b0, uu_q})) * 65'(p9);
  assign u3_d    = 72'(uu_q) * 72'(u_q);

  // --------------------------------------------------------------------------
  // Stage 3: linearized temperature, outer Horner coefficients
  // --------------------------------------------------------------------------
  logic signed [57:0]             ddt3;
  logic signed [bpc_pkg::TlW-1:0] tl_d, tl_q;
  logic signed [bpc_pkg::B1W-1:0] b1_d, b1_q;
  logic signed [bpc_pkg::B0W-1:0] b0a_d, b0a_q;
  logic signed [80:0]             u3p11_d, u3p11_q;

  assign ddt3    = 58'(dd_q) * 58'(t3);
  assign tl_d    = (bpc_pkg::TlW'(dt2_q) <<< 18) + bpc_pkg::TlW'(ddt3);
  assign b1_d    = (bpc_pkg::B1W'($signed({1'b0, p6})) <<< 42)
                 + (bpc_pkg::B1W'(up2_2_q) <<< 19) + bpc_pkg::B1W'(u2p10_q);
  assign b0a_d   = (bpc_pkg::B0W'($signed({1'b0, p5})) <<< 68)
                 + (bpc_pkg::B0W'(up1_2_q) <<< 45) + (bpc_pkg::B0W'(u2p9_q) <<< 17);
  assign u3p11_d = 81'($signed({1'b0, u3_q})) * 81'(p11);

  // --------------------------------------------------------------------------
  // Stage 4: temperature rounding and clamp, constant term finish
  // --------------------------------------------------------------------------
  localparam logic signed [60:0] TRnd = 61'sd1 <<< 39;

  logic signed [60:0] tsum;
  logic signed [20:0] tr;
  logic signed [15:0] tq_d;
  logic               tclip_d;

  assign tsum = 61'(tl_q) + TRnd;
  assign tr   = tsum[60:40];

  always_comb begin
    tclip_d = 1'b0;
    tq_d    = tr[15:0];
    priority if (tr > 21'sd32767) begin
      tq_d    = 16'sh7fff;
      tclip_d = 1'b1;
    end else if (tr < -21'sd32768) begin
      tq_d    = -16'sh8000;
      tclip_d = 1'b1;
    end else begin
      tq_d = tr[15:0];
    end
  end

  // Delay lines that keep operands aligned with the Horner units
  logic signed [bpc_pkg::TlW-1:0] tl_pipe_q [4:9];
  logic signed [bpc_pkg::B1W-1:0] b1_pipe_q [4:6];
  logic signed [bpc_pkg::B0W-1:0] b0_pipe_q [4:9];
  logic signed [15:0]             tq_pipe_q [4:12];
  logic                           tclip_pipe_q [4:12];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d_q   <= d_d;
      u_q   <= raw_pressure_i;
      up1_q <= up1_d;
      up2_q <= up2_d;
      up3_q <= up3_d;
      up4_q <= up4_d;
      uu_q  <= uu_d;
    end
    if (en[2]) begin
      dt2_q   <= dt2_d;
      dd_q    <= dd_d;
      b3_q    <= b3_d;
      b2_q    <= b2_d;
      u2p10_q <= u2p10_d;
      u2p9_q  <= u2p9_d;
      u3_q    <= u3_d;
      up1_2_q <= up1_q;
      up2_2_q <= up2_q;
    end
    if (en[3]) begin
      tl_q    <= tl_d;
      b3_3_q  <= b3_q;
      b2_3_q  <= b2_q;
      b1_q    <= b1_d;
      b0a_q   <= b0a_d;
      u3p11_q <= u3p11_d;
    end
    if (en[4]) begin
      tl_pipe_q[4]    <= tl_q;
      b1_pipe_q[4]    <= b1_q;
      b0_pipe_q[4]    <= b0a_q + bpc_pkg::B0W'(u3p11_q);
      tq_pipe_q[4]    <= tq_d;
      tclip_pipe_q[4] <= tclip_d;
    end
    for (int k = 5; k <= 9; k++) begin
      if (en[k]) begin
        tl_pipe_q[k] <= tl_pipe_q[k-1];
        b0_pipe_q[k] <= b0_pipe_q[k-1];
      end
    end
    for (int k = 5; k <= 6; k++) begin
      if (en[k]) begin
        b1_pipe_q[k] <= b1_pipe_q[k-1];
      end
    end
    for (int k = 5; k <= 12; k++) begin
      if (en[k]) begin
        tq_pipe_q[k]    <= tq_pipe_q[k-1];
        tclip_pipe_q[k] <= tclip_pipe_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4..12: Horner evaluation of the cubic in t_lin
  //   X = T*B3 + B2*2^53, Y = T*X + B1*2^85, S = T*Y + B0*2^116
  // --------------------------------------------------------------------------
  logic signed [bpc_pkg::XW-1:0] x_w;
  logic signed [bpc_pkg::YW-1:0] y_w;
  logic signed [bpc_pkg::SW-1:0] s_w;

  bpc_mul_add #(
    .AW(bpc_pkg::TlW), .BW(bpc_pkg::B3W), .CW(bpc_pkg::B2W),
    .CSH(bpc_pkg::B2Sh), .YW(bpc_pkg::XW)
  ) u_horner_x (
    .clk_i (clk_i),
    .en_i  (en[6:4]),
    .a_i   (tl_q),
    .b_i   (b3_3_q),
    .c_i   (b2_3_q),
    .y_o   (x_w)
  );

  bpc_mul_add #(
    .AW(bpc_pkg::TlW), .BW(bpc_pkg::XW), .CW(bpc_pkg::B1W),
    .CSH(bpc_pkg::B1Sh), .YW(bpc_pkg::YW)
  ) u_horner_y (
    .clk_i (clk_i),
    .en_i  (en[9:7]),
    .a_i   (tl_pipe_q[6]),
    .b_i   (x_w),
    .c_i   (b1_pipe_q[6]),
    .y_o   (y_w)
  );

  bpc_mul_add #(
    .AW(bpc_pkg::TlW), .BW(bpc_pkg::YW), .CW(bpc_pkg::B0W),
    .CSH(bpc_pkg::B0Sh), .YW(bpc_pkg::SW)
  ) u_horner_s (
    .clk_i (clk_i),
    .en_i  (en[12:10]),
    .a_i   (tl_pipe_q[9]),
    .b_i   (y_w),
    .c_i   (b0_pipe_q[9]),
    .y_o   (s_w)
  );

  // --------------------------------------------------------------------------
  // Stage 13: round pressure to 1/64 Pa, clamp, output register
  // --------------------------------------------------------------------------
  localparam logic signed [bpc_pkg::SW-1:0] PRnd = bpc_pkg::SW'(1) <<< 174;

  logic signed [bpc_pkg::SW-1:0] psum;
  logic signed [41:0]            pr;
  logic [23:0]                   pq_d;
  logic                          pclip_d;

  assign psum = s_w + PRnd;
  assign pr   = psum[bpc_pkg::SW-1:175];

  always_comb begin
    pclip_d = 1'b0;
    pq_d    = pr[23:0];
    priority if (pr[41]) begin
      pq_d    = '0;
      pclip_d = 1'b1;
    end else if (pr > 42'sd16777215) begin
      pq_d    = 24'hffffff;
      pclip_d = 1'b1;
    end else begin
      pq_d = pr[23:0];
    end
  end

  logic signed [15:0] temp_out_q;
  logic [23:0]        press_out_q;
  logic               clip_q;

  always_ff @(posedge clk_i) begin
    if (en[NST]) begin
      temp_out_q  <= tq_pipe_q[12];
      press_out_q <= pq_d;
      clip_q      <= tclip_pipe_q[12] | pclip_d;
    end
  end

  assign out_valid_o       = v_q[NST];
  assign temperature_out_o = temp_out_q;
  assign pressure_out_o    = press_out_q;
  assign clipped_o         = clip_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input back-pressure only ever comes from a stalled full pipe
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && (&v_q)))
    else $error("input stalled without a full, blocked pipeline");

  // A result away from every bound is never flagged as clipped
  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pressure_out_o != 24'h000000 && pressure_out_o != 24'hffffff
     && temperature_out_o != 16'sh7fff && temperature_out_o != -16'sh8000)
    |-> !clipped_o)
    else $error("clipped set on an in-range result");

endmodule

FILE: tb/tb_baro_pressure_temp_compensation_core.sv
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation_core: self-checking bench for the core
// Loads calibration sets from zero to full scale, drives raw samples with
// random gaps and output stalls, and compares every result with an exact
// wide-integer evaluation of the compensation polynomial.
// ----------------------------------------------------------------------------
module tb_baro_pressure_temp_compensation_core;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [23:0]        pressure;
    logic               clipped;
  } comp_result_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = bpc_pkg::NumStages + 8;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [bpc_pkg::CfgIdxW-1:0]  cfg_index_i = bpc_pkg::CFG_TEMP_CAL;
  logic [bpc_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [23:0]                  raw_pressure_i = '0;
  logic [23:0]                  raw_temperature_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic signed [15:0]           temperature_out_o;
  logic [23:0]                  pressure_out_o;
  logic                         clipped_o;

  // Calibration copies held by the bench
  logic [39:0] temp_cal_q;
  logic [47:0] press_a_q, press_b_q;
  logic [31:0] press_c_q;

  comp_result_t expected_results[$];
  int unsigned  errors = 0;
  int unsigned  samples_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  clip_count = 0;
  int unsigned  cycle_count = 0;
  bit           send_idle = 1'b0;
  bit           recv_idle = 1'b0;

  baro_pressure_temp_compensation_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Evaluate the compensation exactly: pressure held as S / 2^181 Pa
  function automatic comp_result_t compensate(logic [23:0] raw_p, logic [23:0] raw_t);
    comp_result_t res;
    wide_t u, tl, t2w, t3w, d, acc, tq, pq;
    wide_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    u   = wide_t'(raw_p);
    t1  = wide_t'(temp_cal_q[15:0]);
    t2  = wide_t'(temp_cal_q[31:16]);
    t3  = wide_t'($signed(temp_cal_q[39:32]));
    p1  = wide_t'($signed(press_a_q[15:0]));
    p2  = wide_t'($signed(press_a_q[31:16]));
    p3  = wide_t'($signed(press_a_q[39:32]));
    p4  = wide_t'($signed(press_a_q[47:40]));
    p5  = wide_t'(press_b_q[15:0]);
    p6  = wide_t'(press_b_q[31:16]);
    p7  = wide_t'($signed(press_b_q[39:32]));
    p8  = wide_t'($signed(press_b_q[47:40]));
    p9  = wide_t'($signed(press_c_q[15:0]));
    p10 = wide_t'($signed(press_c_q[23:16]));
    p11 = wide_t'($signed(press_c_q[31:24]));
    res.clipped = 1'b0;

    d   = wide_t'(raw_t) - t1 * 256;
    tl  = d * t2 * 262144 + d * d * t3;
    t2w = tl * tl;
    t3w = t2w * tl;

    // Round temperature to 1/256 degC, ties upward, then saturate
    tq = (tl + (wide_t'(1) <<< 39)) >>> 40;
    if (tq > 32767) begin
      tq = wide_t'(32767);
      res.clipped = 1'b1;
    end else if (tq < -32768) begin
      tq = wide_t'(-32768);
      res.clipped = 1'b1;
    end
    res.temperature = tq[15:0];

    acc = (p5 <<< 184) + ((p6 * tl) <<< 127) + ((p7 * t2w) <<< 77)
        + ((p8 * t3w) <<< 22) + ((u * (p1 - 16384)) <<< 161)
        + ((u * (p2 - 16384) * tl) <<< 104) + ((u * p3 * t2w) <<< 53)
        + u * p4 * t3w + ((p9 * u * u) <<< 133) + ((u * u * p10 * tl) <<< 85)
        + ((u * p11 * u * u) <<< 116);
    pq = (acc + (wide_t'(1) <<< 174)) >>> 175;
    if (pq < 0) begin
      res.pressure = '0;
      res.clipped  = 1'b1;
    end else if (pq > wide_t'(24'hFFFFFF)) begin
      res.pressure = 24'hFFFFFF;
      res.clipped  = 1'b1;
    end else begin
      res.pressure = pq[23:0];
    end
    return res;
  endfunction

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    comp_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result: temp %0d press %0d clip %0d",
               temperature_out_o, pressure_out_o, clipped_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.clipped) clip_count <= clip_count + 1;
        if (temperature_out_o !== exp_r.temperature) begin
          $error("temperature_out: expected %0d, got %0d", exp_r.temperature,
                 temperature_out_o);
          errors++;
        end
        if (pressure_out_o !== exp_r.pressure) begin
          $error("pressure_out: expected %0d, got %0d", exp_r.pressure,
                 pressure_out_o);
          errors++;
        end
        if (clipped_o !== exp_r.clipped) begin
          $error("clipped: expected %0d, got %0d", exp_r.clipped, clipped_o);
          errors++;
        end
      end
    end
  end

  // Receiver: when recv_idle is set, drop out_ready_i for a random gap before each result
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = recv_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Send one raw sample; keep valid high across back-to-back transactions
  task automatic send_sample(logic [23:0] raw_p, logic [23:0] raw_t);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= raw_p;
    raw_temperature_i <= raw_t;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(compensate(raw_p, raw_t));
    samples_sent++;
  endtask

  // Hold off until every result is back and the pipe has emptied
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cal(bpc_pkg::cfg_idx_e idx, logic [bpc_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      bpc_pkg::CFG_TEMP_CAL: temp_cal_q = data[39:0];
      bpc_pkg::CFG_PRESS_A:  press_a_q  = data[47:0];
      bpc_pkg::CFG_PRESS_B:  press_b_q  = data[47:0];
      default:               press_c_q  = data[31:0];
    endcase
  endtask

  task automatic load_cal(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                          logic [47:0] pc);
    drain_pipe();
    write_cal(bpc_pkg::CFG_TEMP_CAL, tc);
    write_cal(bpc_pkg::CFG_PRESS_A, pa);
    write_cal(bpc_pkg::CFG_PRESS_B, pb);
    write_cal(bpc_pkg::CFG_PRESS_C, pc);
  endtask

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  function automatic logic [23:0] rand24();
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // Typical sensor calibration around which realistic samples land
  task automatic load_typical_cal();
    load_cal({8'hF6, 16'd19000, 16'd27500},
             {8'd6, 8'hF8, 16'hFFEC, 16'hFF9A} ,
             {8'hF4, 8'd3, 16'd46000, 16'd28000},
             {8'hF0, 8'd10, 16'd2000});
  endtask

  // Extremes of both sample fields under all-zero, all-one, mixed-extreme and typical sets
  task automatic test_directed();
    logic [23:0] edges[4];
    edges = '{24'h000000, 24'h000001, 24'h800000, 24'hFFFFFF};
    send_idle = 1'b0;
    recv_idle = 1'b0;
    foreach (edges[i]) send_sample(edges[i], edges[3 - i]);
    load_cal('1, '1, '1, '1);
    foreach (edges[i]) send_sample(edges[i], edges[i]);
    load_cal({8'h00, 8'h7F, 16'hFFFF, 16'h0000}, {8'h80, 8'h7F, 16'h8000, 16'h7FFF},
             {8'h7F, 8'h80, 16'hFFFF, 16'h0000}, {16'h0000, 8'h80, 8'h7F, 16'h8000});
    foreach (edges[i]) send_sample(edges[i], edges[(i + 1) % 4]);
    load_typical_cal();
    send_sample(24'd6500000, 24'd7040000);
    send_sample(24'd5000000, 24'd7040000);
    send_sample(24'd7000000, 24'd8200000);
    send_sample(24'd6000000, 24'd6500000);
    send_sample(24'd0, 24'd7040000);
    send_sample(24'hFFFFFF, 24'd7040000);
  endtask

  // Realistic calibration with samples near the working range
  task automatic test_realistic(int unsigned n);
    load_typical_cal();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (n)
      send_sample(24'(4000000 + $urandom_range(0, 4000000)),
                  24'(6000000 + $urandom_range(0, 3000000)));
  endtask

  // Fully random calibration and samples, idling toggled per phase
  task automatic test_random_cal(int unsigned phases, int unsigned n);
    repeat (phases) begin
      load_cal(rand48(), rand48(), rand48(), rand48());
      send_idle = $urandom_range(0, 2) != 0;
      recv_idle = $urandom_range(0, 2) != 0;
      repeat (n) send_sample(rand24(), rand24());
    end
  endtask

  // Sender pauses mid-stream until all results are back, then resumes
  task automatic test_pause_drain();
    send_idle = 1'b0;
    recv_idle = 1'b1;
    repeat (30) send_sample(rand24(), rand24());
    drain_pipe();
    repeat (30) send_sample(rand24(), rand24());
  endtask

  initial begin
    temp_cal_q = '0;
    press_a_q  = '0;
    press_b_q  = '0;
    press_c_q  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_realistic(400);
    test_pause_drain();
    test_random_cal(12, 50);
    test_realistic(140);
    load_cal('0, '0, '0, '0);
    send_sample(24'h123456, 24'h654321);

    drain_pipe();
    $display("Covered %0d samples, %0d results (%0d saturated), over zero, full-scale,",
             samples_sent, results_seen, clip_count);
    $display("typical and random calibration sets with random gaps and stalls.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
